FILE: sv/mersenne_twister_prng_top_defines.svh
// Assertion macros for the MT19937 generator block.
// Used by mersenne_twister_prng_top.sv; expects clk and arst_n in scope.
`ifndef MERSENNE_TWISTER_PRNG_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_PRNG_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication
`define MTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define MTP_ASSERT_IMP(lbl, ante, cons, msg)
`define MTP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/mtp_pkg.sv
// Shared constants, unit opcodes and command type for the MT19937 generator.
// No dependencies; used by mtp_word_unit and mersenne_twister_prng_top.
package mtp_pkg;

	localparam int WORD_W       = 32;
	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;

	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
	localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

	// input operation codes
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// word unit opcodes
	localparam logic [1:0] UOP_ADD    = 2'd0;
	localparam logic [1:0] UOP_MUL    = 2'd1;
	localparam logic [1:0] UOP_TWIST  = 2'd2;
	localparam logic [1:0] UOP_TEMPER = 2'd3;

	typedef struct packed {
		logic       en;
		logic [1:0] op;
	} ucmd_t;

endpackage

FILE: sv/mtp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module mtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: sv/mtp_word_unit.sv
// Shared 32-bit word unit: seed multiply, add, twist step and tempering.
// Depends on mtp_pkg.
module mtp_word_unit (
	input  logic                          clk,
	input  mtp_pkg::ucmd_t                cmd,
	input  logic [mtp_pkg::WORD_W-1:0]    a,
	input  logic [mtp_pkg::WORD_W-1:0]    b,
	input  logic [mtp_pkg::WORD_W-1:0]    c,
	input  logic [5:0]                    bits,
	output logic [mtp_pkg::WORD_W-1:0]    res
);

	logic [mtp_pkg::WORD_W-1:0] res_q;
	logic [mtp_pkg::WORD_W-1:0] nxt;
	logic [mtp_pkg::WORD_W-1:0] y;
	logic [mtp_pkg::WORD_W-1:0] t;
	logic [4:0]                 sh;

	// twist mix and tempering
	always_comb begin
		y  = (a & mtp_pkg::UPPER_MASK) | (b & mtp_pkg::LOWER_MASK);
		t  = a ^ (a >> 11);
		t  = t ^ ((t << 7) & mtp_pkg::TEMPER_B);
		t  = t ^ ((t << 15) & mtp_pkg::TEMPER_C);
		t  = t ^ (t >> 18);
		sh = 5'(6'd32 - bits);
		unique case (cmd.op)
			mtp_pkg::UOP_ADD: begin
				nxt = a + b;
			end
			mtp_pkg::UOP_MUL: begin
				nxt = mtp_pkg::INIT_MULT * (a ^ (a >> 30));
			end
			mtp_pkg::UOP_TWIST: begin
				nxt = c ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_MATRIX : '0);
			end
			mtp_pkg::UOP_TEMPER: begin
				// keep the top bits only; zero bits gives zero, 32 and above gives all
				if (bits == 6'd0) begin
					nxt = '0;
				end else if (bits >= 6'd32) begin
					nxt = t;
				end else begin
					nxt = t >> sh;
				end
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			res_q <= nxt;
		end
	end

	assign res = res_q;

endmodule

FILE: sv/mersenne_twister_prng_top.sv
// Top level of the MT19937 generator: sequencer, state RAM and word unit.
// Depends on mtp_pkg, mtp_ram, mtp_word_unit, mersenne_twister_prng_top_defines.svh.
//
// Use: drive operation, seed_value and bit_count and raise start; the beat is
// taken at a clock edge where start is high and busy is low. A seed beat
// (operation 0) refills the 624-word state and gives no result. A draw beat
// (operation 1) gives one result: random_value with valid high for exactly
// one cycle; the receiver cannot stall and must take it then.
// Sequence: all words are single-port-write RAM sweeps through one word unit:
//   draw from fresh state: read, temper and output states.
//   seed: an add and a write per word; the multiply and the add share the unit.
//   regeneration, on the draw after all 624 words are used: a twist and a
//     write per word, after priming the first word.
//   a draw before any seed first seeds with 5489, then regenerates and draws.
// busy stays high for the whole item; one item is in work at a time.
// Reset leaves the generator unseeded; the state RAM is not cleared, since
// every word is written by seeding before it is read.
`include "mersenne_twister_prng_top_defines.svh"
module mersenne_twister_prng_top #(
	parameter int STATE_WORDS  = mtp_pkg::STATE_WORDS,
	parameter int TWIST_OFFSET = mtp_pkg::TWIST_OFFSET
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       operation,
	input  logic [mtp_pkg::WORD_W-1:0] seed_value,
	input  logic [5:0]                 bit_count,
	output logic                       valid,
	output logic [mtp_pkg::WORD_W-1:0] random_value
);

	localparam int AW = $clog2(STATE_WORDS);
	localparam int NW = $clog2(STATE_WORDS + 1);
	localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SD_INIT = 4'd1;
	localparam logic [3:0] ST_SD_MUL  = 4'd2;
	localparam logic [3:0] ST_SD_ADD  = 4'd3;
	localparam logic [3:0] ST_SD_WR   = 4'd4;
	localparam logic [3:0] ST_RG_PRE  = 4'd5;
	localparam logic [3:0] ST_RG_CUR  = 4'd6;
	localparam logic [3:0] ST_RG_CALC = 4'd7;
	localparam logic [3:0] ST_RG_WR   = 4'd8;
	localparam logic [3:0] ST_DR_RD   = 4'd9;
	localparam logic [3:0] ST_DR_TMP  = 4'd10;
	localparam logic [3:0] ST_DR_OUT  = 4'd11;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
		return (x == LAST) ? '0 : AW'(x + 1'b1);
	endfunction

	logic [3:0]                 state_q;
	logic [NW-1:0]              nidx_q;
	logic                       seeded_q;
	logic                       pend_q;
	logic [AW-1:0]              idx_q;
	logic [AW-1:0]              far_q;
	logic [mtp_pkg::WORD_W-1:0] seed_q;
	logic [5:0]                 bits_q;
	logic [mtp_pkg::WORD_W-1:0] cur_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [mtp_pkg::WORD_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_ra;
	logic [AW-1:0]              ram_rb;
	logic [mtp_pkg::WORD_W-1:0] rdata_a;
	logic [mtp_pkg::WORD_W-1:0] rdata_b;
	logic [AW-1:0]              idx_inc;
	logic [AW-1:0]              far_inc;

	mtp_pkg::ucmd_t             ucmd;
	logic [mtp_pkg::WORD_W-1:0] ua;
	logic [mtp_pkg::WORD_W-1:0] ub;
	logic [mtp_pkg::WORD_W-1:0] uc;
	logic [mtp_pkg::WORD_W-1:0] ures;
	logic                       fast_draw;
	logic                       wr_state;

	assign idx_inc = wrap_inc(idx_q);
	assign far_inc = wrap_inc(far_q);

	// RAM and word unit steering per sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ures;
		ram_ra    = idx_inc;
		ram_rb    = far_q;
		ucmd.en   = 1'b0;
		ucmd.op   = mtp_pkg::UOP_ADD;
		ua        = ures;
		ub        = '0;
		uc        = rdata_b;
		unique case (state_q)
			ST_SD_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = seed_q;
				ucmd.en   = 1'b1;
				ua        = seed_q;
			end
			ST_SD_MUL: begin
				ucmd.en = 1'b1;
				ucmd.op = mtp_pkg::UOP_MUL;
			end
			ST_SD_ADD: begin
				ucmd.en = 1'b1;
				ub      = mtp_pkg::WORD_W'(idx_q);
			end
			ST_SD_WR: begin
				ram_we  = 1'b1;
				ucmd.en = 1'b1;
				ucmd.op = mtp_pkg::UOP_MUL;
			end
			ST_RG_PRE: begin
				ram_ra = '0;
			end
			ST_RG_CALC: begin
				ucmd.en = 1'b1;
				ucmd.op = mtp_pkg::UOP_TWIST;
				ua      = cur_q;
				ub      = rdata_a;
			end
			ST_RG_WR: begin
				// write word i, fetch words i+2 and i+398 for the next step
				ram_we = 1'b1;
				ram_ra = wrap_inc(idx_inc);
				ram_rb = far_inc;
			end
			ST_DR_RD: begin
				ram_ra = nidx_q[AW-1:0];
			end
			ST_DR_TMP: begin
				ucmd.en = 1'b1;
				ucmd.op = mtp_pkg::UOP_TEMPER;
				ua      = rdata_a;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nidx_q   <= NW'(STATE_WORDS);
			seeded_q <= 1'b0;
			pend_q   <= 1'b0;
			idx_q    <= '0;
			far_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (operation == mtp_pkg::OP_SEED) begin
							pend_q  <= 1'b0;
							state_q <= ST_SD_INIT;
						end else begin
							pend_q <= 1'b1;
							if (!seeded_q) begin
								state_q <= ST_SD_INIT;
							end else if (nidx_q == NW'(STATE_WORDS)) begin
								state_q <= ST_RG_PRE;
							end else begin
								state_q <= ST_DR_RD;
							end
						end
					end
				end
				ST_SD_INIT: begin
					idx_q   <= AW'(1);
					state_q <= ST_SD_MUL;
				end
				ST_SD_MUL: begin
					state_q <= ST_SD_ADD;
				end
				ST_SD_ADD: begin
					state_q <= ST_SD_WR;
				end
				ST_SD_WR: begin
					if (idx_q == LAST) begin
						seeded_q <= 1'b1;
						nidx_q   <= NW'(STATE_WORDS);
						state_q  <= pend_q ? ST_RG_PRE : ST_IDLE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SD_ADD;
					end
				end
				ST_RG_PRE: begin
					idx_q   <= '0;
					far_q   <= AW'(TWIST_OFFSET);
					state_q <= ST_RG_CUR;
				end
				ST_RG_CUR: begin
					state_q <= ST_RG_CALC;
				end
				ST_RG_CALC: begin
					state_q <= ST_RG_WR;
				end
				ST_RG_WR: begin
					if (idx_q == LAST) begin
						nidx_q  <= '0;
						state_q <= ST_DR_RD;
					end else begin
						idx_q   <= idx_inc;
						far_q   <= far_inc;
						state_q <= ST_RG_CALC;
					end
				end
				ST_DR_RD: begin
					state_q <= ST_DR_TMP;
				end
				ST_DR_TMP: begin
					nidx_q  <= NW'(nidx_q + 1'b1);
					state_q <= ST_DR_OUT;
				end
				ST_DR_OUT: begin
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// captured beat fields and the carried current word of the twist
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			bits_q <= bit_count;
			seed_q <= (operation == mtp_pkg::OP_SEED) ? seed_value : mtp_pkg::DEFAULT_SEED;
		end
		if (state_q == ST_RG_CUR || state_q == ST_RG_CALC) begin
			cur_q <= rdata_a;
		end
	end

	mtp_ram #(
		.WIDTH (mtp_pkg::WORD_W),
		.DEPTH (STATE_WORDS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_ra),
		.rdata_a (rdata_a),
		.raddr_b (ram_rb),
		.rdata_b (rdata_b)
	);

	mtp_word_unit u_unit (
		.clk  (clk),
		.cmd  (ucmd),
		.a    (ua),
		.b    (ub),
		.c    (uc),
		.bits (bits_q),
		.res  (ures)
	);

	assign busy         = (state_q != ST_IDLE);
	assign valid        = (state_q == ST_DR_OUT);
	assign random_value = ures;

	assign fast_draw = start && !busy && operation == mtp_pkg::OP_DRAW && seeded_q
		&& nidx_q != NW'(STATE_WORDS);

	// states that may write the state RAM
	assign wr_state = state_q == ST_SD_INIT || state_q == ST_SD_WR || state_q == ST_RG_WR;

	// checks
	`MTP_ASSERT_NXT(a_strobe_single, valid, !valid, "result strobe longer than one cycle")
	`MTP_ASSERT_IMP(a_fast_draw_lat, fast_draw, ##3 valid, "draw from fresh state not in 3 cycles")
	`MTP_ASSERT_IMP(a_nidx_range, 1'b1, nidx_q <= NW'(STATE_WORDS), "word index past the state")
	`MTP_ASSERT_IMP(a_we_states, ram_we, wr_state, "state RAM written outside seed or twist")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the MT19937 generator: start/busy command beats in,
// one-cycle valid strobes out. Needs mtp_pkg and mersenne_twister_prng_top.
// An in-bench model of the generator predicts every draw from observed beats.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mtp_pkg::*;

	localparam int TIMEOUT_NS = 2_000_000;
	localparam int ITEM_GOAL  = 1150;
	localparam int QUIET_TAIL = 100;
	localparam int MAX_REPORT = 10;

	// one command beat as queued for the driver
	typedef struct {
		logic        op;
		logic [31:0] seed;
		logic [5:0]  bits;
		bit          drain_first;
	} cmd_beat_t;

	// one draw still owed by the block
	typedef struct {
		logic [5:0]  bits;
		logic [31:0] value;
	} draw_due_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        operation = OP_SEED;
	logic [31:0] seed_value = '0;
	logic [5:0]  bit_count = '0;
	logic        busy;
	logic        valid;
	logic [31:0] random_value;

	cmd_beat_t cmd_todo[$];
	draw_due_t draws_due[$];
	int        gap_left = 0;

	// generator model state
	logic [31:0] mt_words[STATE_WORDS];
	int unsigned word_pos = STATE_WORDS;
	bit          seeded = 1'b0;

	int fail_cnt = 0;
	int seed_cnt = 0;
	int draw_cnt = 0;
	int checked_cnt = 0;
	int regen_cnt = 0;

	mersenne_twister_prng_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.seed_value   (seed_value),
		.bit_count    (bit_count),
		.valid        (valid),
		.random_value (random_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	function automatic void load_seed(input logic [31:0] s);
		logic [31:0] p;
		mt_words[0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			p = mt_words[i-1];
			mt_words[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
		end
		word_pos = STATE_WORDS;
		seeded = 1'b1;
	endfunction

	// in-place twist of all words
	function automatic void twist_all();
		logic [31:0] y;
		logic [31:0] v;
		for (int i = 0; i < STATE_WORDS; i++) begin
			y = (mt_words[i] & UPPER_MASK) | (mt_words[(i + 1) % STATE_WORDS] & LOWER_MASK);
			v = mt_words[(i + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
			if (y[0])
				v = v ^ TWIST_MATRIX;
			mt_words[i] = v;
		end
		word_pos = 0;
		regen_cnt++;
	endfunction

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// next draw: self-seed if needed, regenerate when used up, keep top bits
	function automatic logic [31:0] draw_top_bits(input logic [5:0] nbits);
		logic [31:0] y;
		if (!seeded)
			load_seed(DEFAULT_SEED);
		if (word_pos >= STATE_WORDS)
			twist_all();
		y = temper(mt_words[word_pos]);
		word_pos++;
		if (nbits == 6'd0)
			return '0;
		if (nbits >= 6'd32)
			return y;
		return y >> (32 - nbits);
	endfunction

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		cmd_beat_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			operation <= OP_SEED;
			seed_value <= '0;
			bit_count <= '0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			// no beat offered, or the offered one was just taken
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (cmd_todo.size() == 0) begin
				start <= 1'b0;
			end else if (cmd_todo[0].drain_first &&
					(start || valid || draws_due.size() != 0)) begin
				// hold off until every owed draw has come back
				start <= 1'b0;
			end else begin
				nxt = cmd_todo.pop_front();
				operation <= nxt.op;
				seed_value <= nxt.seed;
				bit_count <= nxt.bits;
				start <= 1'b1;
				if (cmd_todo.size() > QUIET_TAIL && $urandom_range(3) == 0)
					gap_left <= $urandom_range(1, 3);
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		draw_due_t want;
		if (arst_n) begin
			// check the strobed result against the oldest owed draw
			if (valid === 1'b1) begin
				if (draws_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORT)
						$display("%0t: result %08h with no draw pending", $realtime,
							random_value);
				end else begin
					want = draws_due.pop_front();
					checked_cnt++;
					if (random_value !== want.value) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORT)
							$display("%0t: draw of %0d bits: expected %08h, got %08h",
								$realtime, want.bits, want.value, random_value);
					end
				end
			end
			// predict from the beat taken at this edge
			if (start && !busy) begin
				if (operation == OP_SEED) begin
					load_seed(seed_value);
					seed_cnt++;
				end else begin
					want.bits = bit_count;
					want.value = draw_top_bits(bit_count);
					draws_due.push_back(want);
					draw_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic add_seed(input logic [31:0] s, input bit drain);
		cmd_beat_t b;
		b.op = OP_SEED;
		b.seed = s;
		b.bits = 6'($urandom_range(63));
		b.drain_first = drain;
		cmd_todo.push_back(b);
	endtask

	task automatic add_draw(input logic [5:0] nbits, input bit drain);
		cmd_beat_t b;
		b.op = OP_DRAW;
		b.seed = $urandom();
		b.bits = nbits;
		b.drain_first = drain;
		cmd_todo.push_back(b);
	endtask

	function automatic logic [5:0] pick_bits();
		if ($urandom_range(15) == 0)
			return 6'($urandom_range(63));
		return 6'($urandom_range(1, 32));
	endfunction

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return DEFAULT_SEED;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int run_len;
		int bursts;

		// directed: draws before any seed, bit count edges, seed extremes
		add_draw(6'd32, 1'b0);
		add_draw(6'd1, 1'b0);
		add_draw(6'd0, 1'b0);
		add_draw(6'd33, 1'b0);
		add_draw(6'd63, 1'b0);
		add_draw(6'd31, 1'b0);
		add_draw(6'd16, 1'b0);
		add_seed(32'h0000_0000, 1'b0);
		add_draw(6'd32, 1'b0);
		add_seed(32'hffff_ffff, 1'b0);
		add_seed(DEFAULT_SEED, 1'b0);
		add_draw(6'd32, 1'b0);
		add_draw(6'd8, 1'b0);
		add_seed(32'h8000_0001, 1'b1);
		add_draw(6'd32, 1'b0);
		add_draw(6'd1, 1'b1);
		add_seed(32'h7fff_fffe, 1'b0);
		add_draw(6'd24, 1'b0);
		add_draw(6'd32, 1'b0);

		// long draw run: crosses the regeneration point at least once
		for (int i = 0; i < 640; i++)
			add_draw(pick_bits(), i == 320);

		// seeded runs with random content, plus some noise
		bursts = 0;
		while (cmd_todo.size() < ITEM_GOAL) begin
			if ($urandom_range(99) < 8) begin
				if ($urandom_range(1) == 0) begin
					add_seed(pick_seed(), 1'b0);
					add_seed(pick_seed(), 1'b0);
				end else begin
					add_draw(6'($urandom_range(63)), 1'b0);
				end
			end else begin
				add_seed(pick_seed(), (bursts % 6) == 5);
				run_len = $urandom_range(1, 40);
				for (int i = 0; i < run_len; i++)
					add_draw(pick_bits(), 1'b0);
				bursts++;
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all beats taken and all draws back
		do
			@(negedge clk);
		while (cmd_todo.size() != 0 || start || draws_due.size() != 0);
		// a trailing seed may still be running
		repeat (2600) @(negedge clk);
		if (draws_due.size() != 0)
			fail_cnt++;

		$display("Run covered %0d seed beats and %0d draw beats; %0d results checked.",
			seed_cnt, draw_cnt, checked_cnt);
		$display("State regenerated %0d times; %0d failures.", regen_cnt, fail_cnt);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d beats queued and %0d draws owed.", cmd_todo.size(),
			draws_due.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/mtp_pkg.sv
sv/mtp_ram.sv
sv/mtp_word_unit.sv
sv/mersenne_twister_prng_top.sv
bench/tb_top.sv
